// ----- rtl/chained_hash_map_3d_key_core_macros.svh -----
// assertion helpers used by the back-end module (chm3d_back)
`ifndef CHAINED_HASH_MAP_3D_KEY_CORE_MACROS_SVH
`define CHAINED_HASH_MAP_3D_KEY_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("core check failed");

// next-cycle implication, checked out of reset
`define CHM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("core check failed");

`endif

// ----- rtl/chm3d_pkg.sv -----
package chm3d_pkg;

    // BUCKETS is a power of two: the bucket is the low bits of the hash
    localparam int BUCKETS = 256;
    localparam int ENTRIES = 512;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    typedef struct packed {
        logic              is_set;
        logic [31:0]       key_x;
        logic [31:0]       key_y;
        logic [31:0]       key_z;
        logic [31:0]       value;
        logic [BKT_W-1:0]  bucket;
    } t_req;

    typedef enum logic [2:0] {
        F_IDLE, F_XOR, F_MUL0, F_MUL1, F_MUL2, F_FIN
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE, B_HEAD, B_CMP, B_DONE, B_LINK
    } t_bstate;

endpackage

// ----- rtl/chm3d_front.sv -----
module chm3d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_req_type,
    input  logic [31:0]     i_key_x,
    input  logic [31:0]     i_key_y,
    input  logic [31:0]     i_key_z,
    input  logic [31:0]     i_new_value,
    output logic            o_push,
    input  logic            i_q_ready,
    output chm3d_pkg::t_req o_req
);
    import chm3d_pkg::*;

    t_fstate     r_state, n_state;
    logic        r_rnd;
    logic [63:0] r_h;
    logic [63:0] r_acc;
    logic        r_set;
    logic [31:0] r_x, r_y, r_z, r_v;
    logic [63:0] w_c;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_fin;

    // one shared 32x32 multiplier; the 64-bit product mod 2^64 takes three passes
    assign w_c    = r_rnd ? MIX_C2 : MIX_C1;
    assign w_ma   = (r_state == F_MUL2) ? r_h[63:32] : r_h[31:0];
    assign w_mb   = (r_state == F_MUL1) ? w_c[63:32] : w_c[31:0];
    assign w_prod = w_ma * w_mb;
    assign w_fin  = r_h ^ (r_h >> 31);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = F_XOR;
            F_XOR:  n_state = F_MUL0;
            F_MUL0: n_state = F_MUL1;
            F_MUL1: n_state = F_MUL2;
            F_MUL2: n_state = r_rnd ? F_FIN : F_XOR;
            F_FIN:  if (i_q_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE:  o_ready = 1'b1;
            F_FIN:   o_push  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_rnd   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == F_IDLE) r_rnd <= 1'b0;
            else if (r_state == F_MUL2) r_rnd <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: if (i_valid) begin
                r_h   <= {i_key_z[15:0], i_key_y[23:0], i_key_x[23:0]};
                r_set <= i_req_type;
                r_x   <= i_key_x;
                r_y   <= i_key_y;
                r_z   <= i_key_z;
                r_v   <= i_new_value;
            end
            F_XOR:  r_h <= r_rnd ? (r_h ^ (r_h >> 27)) : (r_h ^ (r_h >> 30));
            F_MUL0: r_acc <= w_prod;
            F_MUL1: r_acc[63:32] <= r_acc[63:32] + w_prod[31:0];
            F_MUL2: r_h <= {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};
            default: ;
        endcase
    end

    always_comb begin
        o_req.is_set = r_set;
        o_req.key_x  = r_x;
        o_req.key_y  = r_y;
        o_req.key_z  = r_z;
        o_req.value  = r_v;
        o_req.bucket = w_fin[BKT_W-1:0];
    end

endmodule

// ----- rtl/chm3d_queue.sv -----
module chm3d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  chm3d_pkg::t_req i_req,
    output logic            o_valid,
    input  logic            i_pop,
    output chm3d_pkg::t_req o_req
);
    import chm3d_pkg::*;

    t_req                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QPTR_W:0]     r_cnt;
    logic                w_wr, w_rd;

    assign o_ready = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= QPTR_W'((r_wp + 1'b1) % QDEPTH);
            if (w_rd) r_rp <= QPTR_W'((r_rp + 1'b1) % QDEPTH);
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (w_rd && !w_wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_req;
    end

endmodule

// ----- rtl/chm3d_back.sv -----
module chm3d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_pop,
    input  chm3d_pkg::t_req i_q_req,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_read_value,
    output logic            o_found,
    output logic            o_pool_full
);
    import chm3d_pkg::*;

    t_bstate          r_state, n_state;
    logic [CNT_W-1:0] r_used;
    logic             r_hv [BUCKETS];
    logic             r_hv_q;
    logic             r_ov;
    logic [31:0]      r_ord;
    logic             r_of, r_opf;

    t_req             r_req;
    logic [IDX_W-1:0] r_cur, r_last, r_new;
    logic             r_have_last, r_found;
    logic [CNT_W-1:0] r_steps;

    logic [IDX_W-1:0] head_mem [BUCKETS];
    logic [95:0]      key_mem  [ENTRIES];
    logic [31:0]      val_mem  [ENTRIES];
    logic [IDX_W:0]   next_mem [ENTRIES];
    logic [IDX_W-1:0] r_hidx;
    logic [95:0]      r_rkey;
    logic [31:0]      r_rval;
    logic [IDX_W:0]   r_rnext;

    logic             w_hit, w_free, w_done, w_last_step;
    logic             w_append, w_full, w_upd;
    logic [IDX_W-1:0] w_rd_addr, w_new_idx;

    assign w_hit       = (r_rkey == {r_req.key_x, r_req.key_y, r_req.key_z});
    assign w_free      = !r_ov || i_ready;
    assign w_last_step = !r_rnext[IDX_W] ||
                         (CNT_W'(r_steps + 1'b1) == CNT_W'(ENTRIES));
    assign w_full      = (r_used == CNT_W'(ENTRIES));
    assign w_append    = r_req.is_set && !r_found && !w_full;
    assign w_upd       = r_req.is_set && r_found;
    assign w_new_idx   = r_used[IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_q_valid) n_state = B_HEAD;
            B_HEAD: n_state = r_hv_q ? B_CMP : B_DONE;
            B_CMP:  if (w_hit || w_last_step) n_state = B_DONE;
            B_DONE: if (w_free) n_state = (w_append && r_have_last) ? B_LINK : B_IDLE;
            B_LINK: n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        w_done    = 1'b0;
        w_rd_addr = r_cur;
        unique case (r_state)
            B_IDLE: o_pop = i_q_valid;
            B_HEAD: w_rd_addr = r_hidx;
            B_CMP:  if (!w_hit) w_rd_addr = r_rnext[IDX_W-1:0];
            B_DONE: w_done = w_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_used  <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) r_hv[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (w_done && w_append) begin
                r_used <= r_used + 1'b1;
                if (!r_have_last) r_hv[r_req.bucket] <= 1'b1;
            end
        end
    end

    // walk bookkeeping and result register
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_req  <= i_q_req;
                r_hv_q <= r_hv[i_q_req.bucket];
            end
            B_HEAD: begin
                r_cur       <= r_hidx;
                r_steps     <= '0;
                r_have_last <= 1'b0;
                r_found     <= 1'b0;
            end
            B_CMP: begin
                if (w_hit) begin
                    r_found <= 1'b1;
                end else begin
                    r_last      <= r_cur;
                    r_have_last <= 1'b1;
                    r_steps     <= r_steps + 1'b1;
                    r_cur       <= r_rnext[IDX_W-1:0];
                end
            end
            B_DONE: if (w_free) begin
                r_ord <= (!r_req.is_set && r_found) ? r_rval : 32'd0;
                r_of  <= r_found;
                r_opf <= r_req.is_set && !r_found && w_full;
                r_new <= w_new_idx;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hidx <= head_mem[i_q_req.bucket];
        if (w_done && w_append && !r_have_last) head_mem[r_req.bucket] <= w_new_idx;
    end

    always_ff @(posedge i_clk) begin
        r_rkey <= key_mem[w_rd_addr];
        if (w_done && w_append)
            key_mem[w_new_idx] <= {r_req.key_x, r_req.key_y, r_req.key_z};
    end

    always_ff @(posedge i_clk) begin
        r_rval <= val_mem[w_rd_addr];
        if (w_done && w_upd) val_mem[r_cur] <= r_req.value;
        else if (w_done && w_append) val_mem[w_new_idx] <= r_req.value;
    end

    always_ff @(posedge i_clk) begin
        r_rnext <= next_mem[w_rd_addr];
        if (r_state == B_LINK) next_mem[r_last] <= {1'b1, r_new};
        else if (w_done && w_append) next_mem[w_new_idx] <= '0;
    end

    assign o_valid      = r_ov;
    assign o_read_value = r_ord;
    assign o_found      = r_of;
    assign o_pool_full  = r_opf;

`include "chained_hash_map_3d_key_core_macros.svh"

    `CHM_ASSERT_IMP(a_full_not_found, i_clk, i_rst_n, o_valid, !(o_found && o_pool_full))
    `CHM_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CNT_W'(ENTRIES))
    `CHM_ASSERT_IMP(a_link_after_done, i_clk, i_rst_n, r_state == B_LINK, $past(r_state) == B_DONE)
    `CHM_ASSERT_NXT(a_done_sets_out, i_clk, i_rst_n, w_done, o_valid)

endmodule

// ----- rtl/chained_hash_map_3d_key_core.sv -----
// channel   | valid    | ready    | payload
// request   | i_valid  | o_ready  | i_req_type, i_key_x, i_key_y, i_key_z, i_new_value
// result    | o_valid  | i_ready  | o_read_value, o_found, o_pool_full
//
// Hashing: two xor-shift/multiply rounds of four steps on one shared 32x32 multiplier
// (three passes per product), then a finish; no new request until the finish pushes.
// Walk: pop, head read, a compare per entry visited (one entry-memory read port),
// done, and a link to append to a non-empty chain. A two-deep queue overlaps the two.
// Reset (synchronous, active low) empties all buckets and the pool; no sweep.
// A held result stalls the walk; the front stalls only when the queue is full.
module chained_hash_map_3d_key_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_key_x,
    input  logic [31:0] i_key_y,
    input  logic [31:0] i_key_z,
    input  logic [31:0] i_new_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_value,
    output logic        o_found,
    output logic        o_pool_full
);
    import chm3d_pkg::*;

    logic w_push, w_q_ready, w_q_valid, w_pop;
    t_req w_f_req, w_q_req;

    chm3d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_key_x     (i_key_x),
        .i_key_y     (i_key_y),
        .i_key_z     (i_key_z),
        .i_new_value (i_new_value),
        .o_push      (w_push),
        .i_q_ready   (w_q_ready),
        .o_req       (w_f_req)
    );

    chm3d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_req   (w_f_req),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_req   (w_q_req)
    );

    chm3d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_pop        (w_pop),
        .i_q_req      (w_q_req),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_found      (o_found),
        .o_pool_full  (o_pool_full)
    );

endmodule
